@@ sv/bnf_pkg.sv @@
package bnf_pkg;

  // Geometry of the channel stores
  localparam int CHANNELS = 64;
  localparam int CH_W     = 6;

  // Accumulator and arithmetic unit widths
  localparam int SUM_W  = 36;
  localparam int SQ_W   = 52;
  localparam int DVD_W  = 52;
  localparam int DVS_W  = 33;
  localparam int RAD_W  = 50;
  localparam int ROOT_W = 25;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_TRAIN    = 2'd0;
  localparam logic [1:0] REG_ELEMENTS = 2'd1;
  localparam logic [1:0] REG_MOMENTUM = 2'd2;
  localparam logic [1:0] REG_EPSILON  = 2'd3;

  // Register reset values
  localparam logic        TRAIN_RST    = 1'b1;
  localparam logic [20:0] ELEMENTS_RST = 21'd1024;
  localparam logic [15:0] MOMENTUM_RST = 16'd58982;
  localparam logic [15:0] EPSILON_RST  = 16'd1;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ACC  = 2'd1,
    MODE_FIN  = 2'd2,
    MODE_NORM = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [CH_W-1:0]     channel;
    logic signed [15:0]  sample;
    logic signed [15:0]  shift_value;
  } bnf_in_t;

  typedef struct packed {
    logic signed [15:0]  normalized;
    logic [CH_W-1:0]     out_channel;
    logic                saturated;
  } bnf_out_t;

  // Classified request handed from front to back
  typedef struct packed {
    mode_t               op;
    logic [CH_W-1:0]     channel;
    logic signed [15:0]  sample;
    logic signed [15:0]  shift_value;
  } bnf_req_t;

  typedef struct packed {
    logic        train_mode;
    logic [20:0] elements_per_channel;
    logic [15:0] momentum;
    logic [15:0] epsilon;
  } bnf_cfg_t;

endpackage

@@ sv/batch_norm_forward.sv @@
// Per-channel batch normalisation, Q8.8, with running statistics.
// Input channel: drive in_data and raise in_push; a request is taken when
// in_full is low. Mode 0 loads scale and shift, mode 1 accumulates a sample,
// mode 2 finalises a channel, mode 3 normalises a sample and is the only
// request that yields a result.
// Result channel: while out_empty is low the oldest result is on out_data;
// raise out_pop to take it. Results keep request order.
// Flow: a two-entry input queue feeds a sequencer that handles one request
// at a time, so it starts a new request only once the last one is through.
// Normalise reads the channel stores and multiplies in S_NMUL1 and S_NMUL2
// before its result is queued. A finalise uses the shared bit-serial divider
// (three times in train mode, once in inference) and then the square-root unit.
// A stalled receiver fills the two-entry result queue; normalise requests
// then wait, and the input queue fills and raises in_full.
// Reset (rst_n low, synchronous) empties both queues, restores the
// registers and makes every channel's statistics read as zero.
// Registers are written through the cfg_ APB port at byte address 4*index;
// the user must write them only while the block is idle (not enforced).
module batch_norm_forward (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  bnf_pkg::bnf_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output bnf_pkg::bnf_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import bnf_pkg::*;

  bnf_cfg_t cfg_r;
  bnf_req_t req;
  logic     req_valid, req_ready, wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.train_mode           <= TRAIN_RST;
      cfg_r.elements_per_channel <= ELEMENTS_RST;
      cfg_r.momentum             <= MOMENTUM_RST;
      cfg_r.epsilon              <= EPSILON_RST;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_TRAIN:    cfg_r.train_mode           <= cfg_pwdata[0];
        REG_ELEMENTS: cfg_r.elements_per_channel <= cfg_pwdata[20:0];
        REG_MOMENTUM: cfg_r.momentum             <= cfg_pwdata[15:0];
        REG_EPSILON:  cfg_r.epsilon              <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_TRAIN:    cfg_prdata = 32'(cfg_r.train_mode);
      REG_ELEMENTS: cfg_prdata = 32'(cfg_r.elements_per_channel);
      REG_MOMENTUM: cfg_prdata = 32'(cfg_r.momentum);
      REG_EPSILON:  cfg_prdata = 32'(cfg_r.epsilon);
      default:      cfg_prdata = '0;
    endcase
  end

  bnf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  bnf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ sv/bnf_div.sv @@
module bnf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [bnf_pkg::DVD_W-1:0]  dividend,
  input  logic [bnf_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [bnf_pkg::DVD_W-1:0]  quot,
  output logic [bnf_pkg::DVS_W-1:0]  rem
);
  import bnf_pkg::*;

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   rs, diff;
  logic             ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    rs      = {rem_r, q_r[DVD_W-1]};
    diff    = rs - {1'b0, dvs_r};
    ge      = rs >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : rs[DVS_W-1:0];
    q_nxt   = {q_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

@@ sv/bnf_sqrt.sv @@
module bnf_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [bnf_pkg::RAD_W-1:0]   radicand,
  output logic                        done,
  output logic [bnf_pkg::ROOT_W-1:0]  root
);
  import bnf_pkg::*;

  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W:0]   rem_r, rem_nxt;
  logic [4:0]        cnt_r;
  logic              busy_r, done_r;
  logic [ROOT_W+2:0] rs, trial, diff;
  logic              ge;

  // Two radicand bits per cycle, one root bit out
  always_comb begin
    rs      = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    trial   = {1'b0, root_r, 2'b01};
    diff    = rs - trial;
    ge      = rs >= trial;
    rem_nxt = ge ? diff[ROOT_W:0] : rs[ROOT_W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ sv/bnf_front.sv @@
module bnf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  bnf_pkg::bnf_in_t  in_data,
  output logic              req_valid,
  input  logic              req_ready,
  output bnf_pkg::bnf_req_t req
);
  import bnf_pkg::*;

  bnf_req_t   q_r [2];
  bnf_req_t   cls;
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push_ok, pop_ok;

  // Classify the incoming request by mode
  always_comb begin
    cls.op          = mode_t'(in_data.mode);
    cls.channel     = in_data.channel;
    cls.sample      = in_data.sample;
    cls.shift_value = in_data.shift_value;
  end

  assign in_full   = cnt_r == 2'd2;
  assign req_valid = cnt_r != 2'd0;
  assign req       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = req_valid && req_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= !wp_r;
      if (pop_ok)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cls;
  end

endmodule

@@ sv/bnf_back.sv @@
module bnf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bnf_pkg::bnf_cfg_t  cfg,
  input  logic               req_valid,
  output logic               req_ready,
  input  bnf_pkg::bnf_req_t  req,
  output logic               out_empty,
  input  logic               out_pop,
  output bnf_pkg::bnf_out_t  out_data
);
  import bnf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_ACC, S_FDIV1, S_FDIV2, S_FVAR, S_FRUN1, S_FRUN2,
    S_FV, S_FDIV3, S_FSQRT, S_NMUL1, S_NMUL2, S_NOUT
  } state_t;

  state_t state_r;
  bnf_req_t cur_r;

  // Channel stores with registered reads
  logic [SUM_W+SQ_W-1:0] acc_mem [CHANNELS];
  logic [47:0]           run_mem [CHANNELS];
  logic [47:0]           act_mem [CHANNELS];
  logic [31:0]           par_mem [CHANNELS];
  logic [SUM_W+SQ_W-1:0] acc_q_r;
  logic [47:0]           run_q_r, act_q_r;
  logic [31:0]           par_q_r;
  logic [CHANNELS-1:0]   acc_vld_r, run_vld_r, act_vld_r;
  logic                  acc_qv_r, run_qv_r, act_qv_r;

  logic                  acc_we, run_we, act_we, par_we;
  logic [SUM_W+SQ_W-1:0] acc_wd;
  logic [47:0]           run_wd, act_wd;

  // Effective read data (unwritten entries read as zero)
  logic signed [SUM_W-1:0] sum_e;
  logic [SQ_W-1:0]         sq_e;
  logic signed [15:0]      rm_e, am_e;
  logic [31:0]             rv_e, id_e;

  // Finalize datapath
  logic                    start, neg_r;
  logic [SUM_W-1:0]        mag;
  logic [20:0]             n_eff;
  logic signed [15:0]      mean_r, mean_nxt;
  logic [31:0]             msq_r, var_r, var_nxt;
  logic [SQ_W-1:0]         ex2_r, diff;
  logic [DVD_W:0]          qa;
  logic [16:0]             om;
  logic signed [33:0]      pm1_r;
  logic signed [32:0]      pm2_r;
  logic [48:0]             pv1_r;
  logic [47:0]             pv2_r;
  logic signed [34:0]      rm_sum;
  logic [49:0]             rv_sum;
  logic [DVS_W-1:0]        v_raw, v_eff;

  logic                    div_go, div_done, sq_go, sq_done;
  logic [DVD_W-1:0]        div_dvd, div_q;
  logic [DVS_W-1:0]        div_dvs, div_rem;
  logic [ROOT_W-1:0]       root;

  // Normalize datapath
  logic signed [16:0]      d_s;
  logic signed [49:0]      p_r, p_nxt, p_rnd;
  logic signed [41:0]      xn;
  logic signed [58:0]      y_r, y_nxt, y_rnd;
  logic signed [42:0]      r_s;
  bnf_out_t                res;

  // Result queue
  bnf_out_t   oq_r [2];
  logic       owp_r, orp_r, oq_push, oq_pop, oq_full;
  logic [1:0] ocnt_r;

  assign oq_full   = ocnt_r == 2'd2;
  assign out_empty = ocnt_r == 2'd0;
  assign out_data  = oq_r[orp_r];
  assign oq_pop    = out_pop && !out_empty;
  assign oq_push   = state_r == S_NOUT;

  assign start     = state_r == S_IDLE && req_valid &&
                     !(req.op == MODE_NORM && oq_full);
  assign req_ready = start;

  always_comb begin
    sum_e = acc_qv_r ? acc_q_r[SUM_W+SQ_W-1:SQ_W] : '0;
    sq_e  = acc_qv_r ? acc_q_r[SQ_W-1:0] : '0;
    rm_e  = run_qv_r ? run_q_r[47:32] : '0;
    rv_e  = run_qv_r ? run_q_r[31:0] : '0;
    am_e  = act_qv_r ? act_q_r[47:32] : '0;
    id_e  = act_qv_r ? act_q_r[31:0] : '0;
    mag   = sum_e[SUM_W-1] ? SUM_W'(-sum_e) : SUM_W'(sum_e);
    n_eff = (cfg.elements_per_channel == 21'd0) ? 21'd1 : cfg.elements_per_channel;
    om    = 17'h10000 - {1'b0, cfg.momentum};
  end

  // Batch mean: signed floor division, saturated to 16 bits
  always_comb begin
    qa = {1'b0, div_q} + (DVD_W+1)'(neg_r && div_rem != '0);
    if (!neg_r) begin
      mean_nxt = (qa > (DVD_W+1)'(32767)) ? 16'sd32767 : $signed(qa[15:0]);
    end else begin
      mean_nxt = (qa > (DVD_W+1)'(32768)) ? -16'sd32768 : $signed(16'(-qa[16:0]));
    end
  end

  // Batch variance, floored at zero and saturated
  always_comb begin
    diff    = (ex2_r > SQ_W'(msq_r)) ? ex2_r - SQ_W'(msq_r) : '0;
    var_nxt = (diff[SQ_W-1:32] != '0) ? 32'hFFFF_FFFF : diff[31:0];
  end

  always_comb begin
    rm_sum = 35'(pm1_r) + 35'(pm2_r) + 35'sd32768;
    rv_sum = 50'(pv1_r) + 50'(pv2_r) + 50'd32768;
    v_raw  = {1'b0, var_r} + DVS_W'(cfg.epsilon);
    v_eff  = (v_raw == '0) ? DVS_W'(1) : v_raw;
  end

  // Divider and root operand selection
  always_comb begin
    div_go  = 1'b0;
    div_dvd = '0;
    div_dvs = '0;
    sq_go   = state_r == S_FDIV3 && div_done;
    unique case (state_r)
      S_RD: begin
        div_go  = cur_r.op == MODE_FIN && cfg.train_mode;
        div_dvd = DVD_W'(mag);
        div_dvs = DVS_W'(n_eff);
      end
      S_FDIV1: begin
        div_go  = div_done;
        div_dvd = sq_e;
        div_dvs = DVS_W'(n_eff);
      end
      S_FV: begin
        div_go  = 1'b1;
        div_dvd = DVD_W'(1) << 48;
        div_dvs = v_eff;
      end
      default: ;
    endcase
  end

  bnf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  bnf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sq_go),
    .radicand (RAD_W'(div_q[48:0])),
    .done     (sq_done),
    .root     (root)
  );

  // Normalize arithmetic
  always_comb begin
    d_s   = 17'(cur_r.sample) - 17'(am_e);
    p_nxt = 50'(d_s) * $signed({18'd0, id_e});
    p_rnd = p_r + 50'sd128;
    xn    = p_rnd[49:8];
    y_nxt = 59'(xn) * 59'($signed(par_q_r[31:16]))
          + (59'($signed(par_q_r[15:0])) <<< 16);
    y_rnd = y_r + 59'sd32768;
    r_s   = y_rnd[58:16];
    res.out_channel = cur_r.channel;
    if (r_s > 43'sd32767) begin
      res.normalized = 16'sd32767;
      res.saturated  = 1'b1;
    end else if (r_s < -43'sd32768) begin
      res.normalized = -16'sd32768;
      res.saturated  = 1'b1;
    end else begin
      res.normalized = r_s[15:0];
      res.saturated  = 1'b0;
    end
  end

  // Store write ports
  always_comb begin
    acc_we = 1'b0;
    acc_wd = '0;
    run_we = state_r == S_FRUN2;
    run_wd = {rm_sum[31:16], rv_sum[47:16]};
    act_we = state_r == S_FSQRT && sq_done;
    act_wd = {mean_r, 32'(root)};
    par_we = state_r == S_RD && cur_r.op == MODE_LOAD;
    if (state_r == S_ACC) begin
      acc_we = 1'b1;
      acc_wd = {SUM_W'(sum_e + SUM_W'(cur_r.sample)),
                SQ_W'(sq_e + SQ_W'(32'(cur_r.sample * cur_r.sample)))};
    end else if (state_r == S_FRUN2) begin
      acc_we = 1'b1;
    end
  end

  // Read on start, write at the current channel
  always_ff @(posedge clk) begin
    if (start) begin
      acc_q_r <= acc_mem[req.channel];
      run_q_r <= run_mem[req.channel];
      act_q_r <= act_mem[req.channel];
      par_q_r <= par_mem[req.channel];
    end
    if (acc_we) acc_mem[cur_r.channel] <= acc_wd;
    if (run_we) run_mem[cur_r.channel] <= run_wd;
    if (act_we) act_mem[cur_r.channel] <= act_wd;
    if (par_we) par_mem[cur_r.channel] <= {cur_r.sample, cur_r.shift_value};
  end

  // Valid bits stand in for the all-zero reset of the stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
      run_vld_r <= '0;
      act_vld_r <= '0;
      acc_qv_r  <= 1'b0;
      run_qv_r  <= 1'b0;
      act_qv_r  <= 1'b0;
    end else begin
      if (start) begin
        acc_qv_r <= acc_vld_r[req.channel];
        run_qv_r <= run_vld_r[req.channel];
        act_qv_r <= act_vld_r[req.channel];
      end
      if (acc_we) acc_vld_r[cur_r.channel] <= 1'b1;
      if (run_we) run_vld_r[cur_r.channel] <= 1'b1;
      if (act_we) act_vld_r[cur_r.channel] <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) state_r <= S_RD;
        S_RD: begin
          unique case (cur_r.op)
            MODE_LOAD: state_r <= S_IDLE;
            MODE_ACC:  state_r <= S_ACC;
            MODE_FIN:  state_r <= cfg.train_mode ? S_FDIV1 : S_FV;
            MODE_NORM: state_r <= S_NMUL1;
            default:   state_r <= S_IDLE;
          endcase
        end
        S_ACC:   state_r <= S_IDLE;
        S_FDIV1: if (div_done) state_r <= S_FDIV2;
        S_FDIV2: if (div_done) state_r <= S_FVAR;
        S_FVAR:  state_r <= S_FRUN1;
        S_FRUN1: state_r <= S_FRUN2;
        S_FRUN2: state_r <= S_FV;
        S_FV:    state_r <= S_FDIV3;
        S_FDIV3: if (div_done) state_r <= S_FSQRT;
        S_FSQRT: if (sq_done) state_r <= S_IDLE;
        S_NMUL1: state_r <= S_NMUL2;
        S_NMUL2: state_r <= S_NOUT;
        S_NOUT:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) cur_r <= req;
    if (state_r == S_RD) begin
      neg_r  <= sum_e[SUM_W-1];
      mean_r <= rm_e;
      var_r  <= rv_e;
    end
    if (state_r == S_FDIV1 && div_done) mean_r <= mean_nxt;
    if (state_r == S_FDIV2) begin
      msq_r <= 32'(mean_r * mean_r);
      if (div_done) ex2_r <= div_q;
    end
    if (state_r == S_FVAR) var_r <= var_nxt;
    if (state_r == S_FRUN1) begin
      pm1_r <= 34'($signed({1'b0, om})) * 34'(mean_r);
      pm2_r <= 33'($signed({1'b0, cfg.momentum})) * 33'(rm_e);
      pv1_r <= 49'(om) * 49'(var_r);
      pv2_r <= 48'(cfg.momentum) * 48'(rv_e);
    end
    if (state_r == S_NMUL1) p_r <= p_nxt;
    if (state_r == S_NMUL2) y_r <= y_nxt;
  end

  // Hold results until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      if (oq_push) owp_r <= !owp_r;
      if (oq_pop)  orp_r <= !orp_r;
      ocnt_r <= ocnt_r + 2'(oq_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[owp_r] <= res;
  end

endmodule
